@@ rtl/core/gb_cpu_subset_execute_assert.svh @@
// Assertion macros used by the checker module.
`ifndef GB_CPU_SUBSET_EXECUTE_ASSERT_SVH
`define GB_CPU_SUBSET_EXECUTE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define GBSE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gbse_pkg.sv @@
`timescale 1ns / 1ps

package gbse_pkg;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [15:0] operand_bytes;
        logic [15:0] mem_data;
    } in_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [15:0] af_pair;
        logic [15:0] hl_pair;
        logic [15:0] stack_ptr;
        logic        write_enable;
        logic [15:0] write_addr;
        logic [15:0] write_data;
        logic        write_is_word;
        logic [15:0] cycle_count;
        logic        recheck_interrupts;
        logic        unsupported_op;
    } out_t;

    // architectural state: register file slots A F B C D E H L
    typedef struct packed {
        logic [7:0][7:0] rf;
        logic [15:0]     sp;
        logic [15:0]     pc;
        logic [15:0]     cyc;
    } state_t;

    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBC = 3'd3,
        ALU_AND = 3'd4,
        ALU_XOR = 3'd5,
        ALU_OR  = 3'd6,
        ALU_CP  = 3'd7
    } alu_kind_t;

    localparam logic [2:0] SLOT_A = 3'd0;
    localparam logic [2:0] SLOT_F = 3'd1;
    localparam logic [2:0] SLOT_B = 3'd2;
    localparam logic [2:0] SLOT_C = 3'd3;
    localparam logic [2:0] SLOT_D = 3'd4;
    localparam logic [2:0] SLOT_E = 3'd5;
    localparam logic [2:0] SLOT_H = 3'd6;
    localparam logic [2:0] SLOT_L = 3'd7;

    localparam logic [7:0] FLAG_Z = 8'h80;
    localparam logic [7:0] FLAG_N = 8'h40;
    localparam logic [7:0] FLAG_H = 8'h20;
    localparam logic [7:0] FLAG_C = 8'h10;

    // opcode fields
    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_HALT = 8'h76;

    localparam logic [1:0] GRP_MISC = 2'b00;
    localparam logic [1:0] GRP_LD   = 2'b01;
    localparam logic [1:0] GRP_ALU  = 2'b10;
    localparam logic [1:0] GRP_HIGH = 2'b11;

    localparam logic [3:0] LO_LD_RR  = 4'h1;
    localparam logic [3:0] LO_INC_RR = 4'h3;
    localparam logic [3:0] LO_ADD_HL = 4'h9;
    localparam logic [3:0] LO_DEC_RR = 4'hB;
    localparam logic [3:0] LO_POP    = 4'h1;
    localparam logic [3:0] LO_PUSH   = 4'h5;

    localparam logic [2:0] CODE_INC    = 3'd4;
    localparam logic [2:0] CODE_DEC    = 3'd5;
    localparam logic [2:0] CODE_HL_MEM = 3'd6;
    localparam logic [2:0] CODE_IMM    = 3'd6;

    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;
    localparam logic [1:0] PAIR_AF = 2'd3;

    localparam logic [15:0] ADDR_TOP  = 16'hFFFF;
    localparam logic [15:0] ADDR_TOP2 = 16'hFFFE;

    // operand code to register slot; code 6 is (HL) and never reaches here as a register
    function automatic logic [2:0] slot_of(logic [2:0] code);
        logic [2:0] s;
        case (code)
            3'd0:    s = SLOT_B;
            3'd1:    s = SLOT_C;
            3'd2:    s = SLOT_D;
            3'd3:    s = SLOT_E;
            3'd4:    s = SLOT_H;
            3'd5:    s = SLOT_L;
            default: s = SLOT_A;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/gbse_alu.sv @@
`timescale 1ns / 1ps

module gbse_alu import gbse_pkg::*; (
    input  alu_kind_t  kind,
    input  logic [7:0] a,
    input  logic [7:0] b,
    input  logic       carry_in,
    output logic [7:0] result,
    output logic [7:0] flags,
    output logic       write_a
);

    logic       cy;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [7:0] diff;
    logic       z;
    logic       n;
    logic       h;
    logic       c;

    always_comb begin
        cy     = 1'b0;
        sum9   = '0;
        sum5   = '0;
        diff   = '0;
        result = '0;
        n      = 1'b0;
        h      = 1'b0;
        c      = 1'b0;
        case (kind)
            ALU_ADD, ALU_ADC: begin
                cy     = (kind == ALU_ADC) ? carry_in : 1'b0;
                sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cy};
                sum5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
                result = sum9[7:0];
                h      = sum5[4];
                c      = sum9[8];
            end
            ALU_SUB, ALU_SBC, ALU_CP: begin
                cy     = (kind == ALU_SBC) ? carry_in : 1'b0;
                diff   = a - b - {7'd0, cy};
                result = diff;
                n      = 1'b1;
                // borrows out of bit 3 and bit 7
                h      = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'd0, cy});
                c      = {1'b0, a} < ({1'b0, b} + {8'd0, cy});
            end
            ALU_AND: begin
                result = a & b;
                h      = 1'b1;
            end
            ALU_XOR: begin
                result = a ^ b;
            end
            default: begin
                result = a | b;
            end
        endcase
        z = (result == 8'd0);
    end

    assign flags   = {z, n, h, c, 4'b0000};
    assign write_a = (kind != ALU_CP);

endmodule

@@ rtl/core/gbse_exec.sv @@
`timescale 1ns / 1ps

module gbse_exec import gbse_pkg::*; (
    input  state_t st_cur,
    input  in_t    item,
    output state_t state_next,
    output out_t   out_next
);

    logic [7:0]  op;
    logic [15:0] nn;
    logic [7:0]  n8;
    logic [15:0] md;
    logic [7:0]  mb;
    logic [15:0] hl;
    logic [15:0] af;
    logic [1:0]  p;
    logic [2:0]  dst;
    logic [2:0]  src;

    logic [7:0]  src_val;
    logic [7:0]  alu_b;
    logic [7:0]  alu_r;
    logic [7:0]  alu_f;
    logic        alu_wa;

    logic [7:0]  id_v;
    logic        id_dec;
    logic [7:0]  id_r;
    logic        id_h;
    logic [7:0]  id_f;

    logic [15:0] rr_cur;
    logic [16:0] add_s;
    logic [12:0] add_h;
    logic [15:0] sp_dec;

    state_t      ns;
    logic [1:0]  len;
    logic [4:0]  cyc;
    logic        ok;
    logic        we;
    logic        word;
    logic [15:0] waddr;
    logic [15:0] wdata;
    logic        recheck;

    function automatic logic [15:0] rr_get(state_t s, logic [1:0] sel);
        logic [15:0] v;
        case (sel)
            PAIR_BC: v = {s.rf[SLOT_B], s.rf[SLOT_C]};
            PAIR_DE: v = {s.rf[SLOT_D], s.rf[SLOT_E]};
            PAIR_HL: v = {s.rf[SLOT_H], s.rf[SLOT_L]};
            default: v = s.sp;
        endcase
        return v;
    endfunction

    function automatic state_t rr_set(state_t s, logic [1:0] sel, logic [15:0] v);
        state_t r;
        r = s;
        case (sel)
            PAIR_BC: {r.rf[SLOT_B], r.rf[SLOT_C]} = v;
            PAIR_DE: {r.rf[SLOT_D], r.rf[SLOT_E]} = v;
            PAIR_HL: {r.rf[SLOT_H], r.rf[SLOT_L]} = v;
            default: r.sp = v;
        endcase
        return r;
    endfunction

    assign op  = item.opcode;
    assign nn  = item.operand_bytes;
    assign n8  = item.operand_bytes[7:0];
    assign md  = item.mem_data;
    assign mb  = item.mem_data[7:0];
    assign hl  = {st_cur.rf[SLOT_H], st_cur.rf[SLOT_L]};
    assign af  = {st_cur.rf[SLOT_A], st_cur.rf[SLOT_F]};
    assign p   = op[5:4];
    assign dst = op[5:3];
    assign src = op[2:0];

    assign src_val = st_cur.rf[slot_of(src)];
    // register/(HL) operand for the 0x80 block, immediate for the 0xC6 column
    assign alu_b   = (op[7:6] == GRP_ALU) ? ((src == CODE_HL_MEM) ? mb : src_val) : n8;

    gbse_alu u_alu (
        .kind     (alu_kind_t'(dst)),
        .a        (st_cur.rf[SLOT_A]),
        .b        (alu_b),
        .carry_in (st_cur.rf[SLOT_F][4]),
        .result   (alu_r),
        .flags    (alu_f),
        .write_a  (alu_wa)
    );

    // 8-bit INC/DEC keeps C
    assign id_v   = (dst == CODE_HL_MEM) ? mb : st_cur.rf[slot_of(dst)];
    assign id_dec = (src == CODE_DEC);
    assign id_r   = id_dec ? (id_v - 8'd1) : (id_v + 8'd1);
    assign id_h   = id_dec ? (id_v[3:0] == 4'h0) : (id_v[3:0] == 4'hF);
    assign id_f   = {(id_r == 8'd0), id_dec, id_h, 1'b0, 4'b0000} | (st_cur.rf[SLOT_F] & FLAG_C);

    assign rr_cur = rr_get(st_cur, p);
    assign add_s  = {1'b0, hl} + {1'b0, rr_cur};
    assign add_h  = {1'b0, hl[11:0]} + {1'b0, rr_cur[11:0]};
    assign sp_dec = st_cur.sp - 16'd2;

    always_comb begin
        ns    = st_cur;
        len   = 2'd1;
        cyc   = 5'd4;
        ok    = 1'b1;
        we    = 1'b0;
        word  = 1'b0;
        waddr = '0;
        wdata = '0;
        case (op[7:6])
            GRP_MISC: begin
                if (op != OP_NOP) begin
                    case (op[3:0])
                        LO_LD_RR: begin
                            ns  = rr_set(st_cur, p, nn);
                            len = 2'd3;
                            cyc = 5'd12;
                        end
                        LO_INC_RR: begin
                            ns  = rr_set(st_cur, p, rr_cur + 16'd1);
                            cyc = 5'd8;
                        end
                        LO_DEC_RR: begin
                            ns  = rr_set(st_cur, p, rr_cur - 16'd1);
                            cyc = 5'd8;
                        end
                        LO_ADD_HL: begin
                            {ns.rf[SLOT_H], ns.rf[SLOT_L]} = add_s[15:0];
                            ns.rf[SLOT_F] = (st_cur.rf[SLOT_F] & FLAG_Z)
                                          | (add_h[12] ? FLAG_H : 8'h00)
                                          | (add_s[16] ? FLAG_C : 8'h00);
                            cyc = 5'd8;
                        end
                        default: begin
                            if (src == CODE_INC || src == CODE_DEC) begin
                                ns.rf[SLOT_F] = id_f;
                                if (dst == CODE_HL_MEM) begin
                                    we    = 1'b1;
                                    waddr = hl;
                                    wdata = {8'h00, id_r};
                                    cyc   = 5'd12;
                                end else begin
                                    ns.rf[slot_of(dst)] = id_r;
                                end
                            end else if (src == CODE_IMM) begin
                                len = 2'd2;
                                if (dst == CODE_HL_MEM) begin
                                    we    = 1'b1;
                                    waddr = hl;
                                    wdata = {8'h00, n8};
                                    cyc   = 5'd12;
                                end else begin
                                    ns.rf[slot_of(dst)] = n8;
                                    cyc = 5'd8;
                                end
                            end else begin
                                ok = 1'b0;
                            end
                        end
                    endcase
                end
            end
            GRP_LD: begin
                if (op == OP_HALT) begin
                    ok = 1'b0;
                end else if (dst == CODE_HL_MEM) begin
                    we    = 1'b1;
                    waddr = hl;
                    wdata = {8'h00, src_val};
                    cyc   = 5'd8;
                end else begin
                    ns.rf[slot_of(dst)] = (src == CODE_HL_MEM) ? mb : src_val;
                    cyc = (src == CODE_HL_MEM) ? 5'd8 : 5'd4;
                end
            end
            GRP_ALU: begin
                ns.rf[SLOT_F] = alu_f;
                if (alu_wa) begin
                    ns.rf[SLOT_A] = alu_r;
                end
                cyc = (src == CODE_HL_MEM) ? 5'd8 : 5'd4;
            end
            default: begin
                if (src == CODE_IMM) begin
                    ns.rf[SLOT_F] = alu_f;
                    if (alu_wa) begin
                        ns.rf[SLOT_A] = alu_r;
                    end
                    len = 2'd2;
                    cyc = 5'd8;
                end else if (op[3:0] == LO_POP) begin
                    if (p == PAIR_AF) begin
                        ns.rf[SLOT_A] = md[15:8];
                        ns.rf[SLOT_F] = {md[7:4], 4'b0000};
                    end else begin
                        ns = rr_set(st_cur, p, md);
                    end
                    ns.sp = st_cur.sp + 16'd2;
                    cyc   = 5'd12;
                end else if (op[3:0] == LO_PUSH) begin
                    ns.sp = sp_dec;
                    we    = 1'b1;
                    word  = 1'b1;
                    waddr = sp_dec;
                    wdata = (p == PAIR_AF) ? af : rr_cur;
                    cyc   = 5'd16;
                end else begin
                    ok = 1'b0;
                end
            end
        endcase

        if (ok) begin
            ns.pc  = st_cur.pc + {14'd0, len};
            ns.cyc = st_cur.cyc + {11'd0, cyc};
        end else begin
            ns    = st_cur;
            we    = 1'b0;
            word  = 1'b0;
            waddr = '0;
            wdata = '0;
        end
        recheck = we && (word ? (waddr >= ADDR_TOP2) : (waddr == ADDR_TOP));
    end

    assign state_next = ns;

    assign out_next.next_pc            = ns.pc;
    assign out_next.af_pair            = {ns.rf[SLOT_A], ns.rf[SLOT_F]};
    assign out_next.hl_pair            = {ns.rf[SLOT_H], ns.rf[SLOT_L]};
    assign out_next.stack_ptr          = ns.sp;
    assign out_next.write_enable       = we;
    assign out_next.write_addr         = waddr;
    assign out_next.write_data         = wdata;
    assign out_next.write_is_word      = word;
    assign out_next.cycle_count        = ns.cyc;
    assign out_next.recheck_interrupts = recheck;
    assign out_next.unsupported_op     = !ok;

endmodule

@@ rtl/core/gb_cpu_subset_execute.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_data (in_t: opcode, operands, memory operand)
// m_        out        m_valid / m_ready  m_data (out_t: PC, AF, HL, SP, write, status)
//
// One instruction per clock while the result is not stalled: an item is held in
// the input register, executed against the register file, SP, PC and clock count,
// and then registered into the result register once that is free or departing.
// The state register is updated in the same cycle as the result register, so
// throughput is one item per cycle unless the output stalls.
// A stalled result holds the pipe; an input is still taken while the input
// register drains into a free or departing result slot.
// aresetn (synchronous) clears registers A-L, SP, PC, the clock count and both valids.
module gb_cpu_subset_execute import gbse_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    in_t    in_reg;
    logic   in_valid_reg;
    out_t   out_reg;
    logic   out_valid_reg;
    state_t state_reg;
    state_t state_next;
    out_t   out_next;
    logic   advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    gbse_exec u_exec (
        .st_cur     (state_reg),
        .item       (in_reg),
        .state_next (state_next),
        .out_next   (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ rtl/core/gbse_checker.sv @@
`timescale 1ns / 1ps

`include "gb_cpu_subset_execute_assert.svh"

module gbse_checker import gbse_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    logic stall;
    logic res_unsup;
    logic res_recheck;
    logic res_word;
    logic res_write;

    assign stall       = m_valid && !m_ready;
    assign res_unsup   = m_valid && m_data.unsupported_op;
    assign res_recheck = m_valid && m_data.recheck_interrupts;
    assign res_word    = m_valid && m_data.write_is_word;
    assign res_write   = m_data.write_enable;

    `GBSE_ASSERT_NEXT(a_out_hold, stall, m_valid && $stable(m_data), "stalled result changed")
    `GBSE_ASSERT_NOW(a_unsup_no_write, res_unsup, !res_write, "unsupported op wrote memory")
    `GBSE_ASSERT_NOW(a_recheck_write, res_recheck, res_write, "recheck without a write")
    `GBSE_ASSERT_NOW(a_word_write, res_word, res_write, "word flag without a write")
    `GBSE_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "input not ready with no result")

endmodule

bind gb_cpu_subset_execute gbse_checker u_gbse_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ test/gb_cpu_subset_execute_tb.sv @@
`timescale 1ns / 1ps

module gb_cpu_subset_execute_tb;
    import gbse_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1150;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_CHOKE
    } rx_mode_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    gb_cpu_subset_execute dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // architectural state as the CPU should see it
    logic [7:0]  cpu_regs [8];
    logic [15:0] cpu_sp;
    logic [15:0] cpu_pc;
    logic [15:0] cpu_clocks;

    in_t  program_items [$];
    out_t predicted_out [$];
    out_t want;

    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    logic s_taken = 1'b0;

    int burst_left = 1;
    int gap_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int rx_left = 0;
    logic [1:0] rx_phase = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- instruction predictor ----------------

    function automatic logic [15:0] pair_rd(logic [2:0] hi);
        return {cpu_regs[hi], cpu_regs[hi + 3'd1]};
    endfunction

    function automatic void pair_wr(logic [2:0] hi, logic [15:0] v);
        cpu_regs[hi] = v[15:8];
        cpu_regs[hi + 3'd1] = v[7:0];
    endfunction

    function automatic logic [15:0] rr_rd(logic [1:0] p);
        case (p)
            PAIR_BC: return pair_rd(SLOT_B);
            PAIR_DE: return pair_rd(SLOT_D);
            PAIR_HL: return pair_rd(SLOT_H);
            default: return cpu_sp;
        endcase
    endfunction

    function automatic void rr_wr(logic [1:0] p, logic [15:0] v);
        case (p)
            PAIR_BC: pair_wr(SLOT_B, v);
            PAIR_DE: pair_wr(SLOT_D, v);
            PAIR_HL: pair_wr(SLOT_H, v);
            default: cpu_sp = v;
        endcase
    endfunction

    function automatic logic [2:0] code_reg(logic [2:0] code);
        case (code)
            3'd0:    return SLOT_B;
            3'd1:    return SLOT_C;
            3'd2:    return SLOT_D;
            3'd3:    return SLOT_E;
            3'd4:    return SLOT_H;
            3'd5:    return SLOT_L;
            default: return SLOT_A;
        endcase
    endfunction

    function automatic logic [7:0] flag_byte(bit z, bit n, bit h, bit c);
        return (z ? FLAG_Z : 8'h00) | (n ? FLAG_N : 8'h00) |
               (h ? FLAG_H : 8'h00) | (c ? FLAG_C : 8'h00);
    endfunction

    function automatic void alu_apply(alu_kind_t kind, logic [7:0] b);
        int unsigned a, bb, cy, r;
        logic [7:0] f;
        a = cpu_regs[SLOT_A];
        bb = b;
        cy = ((cpu_regs[SLOT_F] & FLAG_C) != 8'h00) ? 1 : 0;
        case (kind)
            ALU_ADD, ALU_ADC: begin
                if (kind == ALU_ADD) cy = 0;
                r = a + bb + cy;
                f = flag_byte((r & 255) == 0, 1'b0, ((a & 15) + (bb & 15) + cy) > 15, r > 255);
            end
            ALU_SUB, ALU_SBC, ALU_CP: begin
                if (kind != ALU_SBC) cy = 0;
                r = (a - bb - cy) & 255;
                f = flag_byte(r == 0, 1'b1, (a & 15) < ((bb & 15) + cy), a < (bb + cy));
            end
            ALU_AND: begin
                r = a & bb;
                f = flag_byte(r == 0, 1'b0, 1'b1, 1'b0);
            end
            ALU_XOR: begin
                r = a ^ bb;
                f = flag_byte(r == 0, 1'b0, 1'b0, 1'b0);
            end
            default: begin
                r = a | bb;
                f = flag_byte(r == 0, 1'b0, 1'b0, 1'b0);
            end
        endcase
        cpu_regs[SLOT_F] = f;
        if (kind != ALU_CP) cpu_regs[SLOT_A] = 8'(r);
    endfunction

    // 8-bit INC/DEC keeps C, recomputes the rest
    function automatic logic [7:0] inc_dec_byte(logic [7:0] v, bit dec);
        logic [7:0] keep, r;
        bit h;
        keep = cpu_regs[SLOT_F] & FLAG_C;
        r = dec ? v - 8'd1 : v + 8'd1;
        h = dec ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF);
        cpu_regs[SLOT_F] = flag_byte(r == 8'h00, dec, h, 1'b0) | keep;
        return r;
    endfunction

    function automatic out_t execute_instr(in_t it);
        logic [7:0] op, n8, mb, v;
        logic [15:0] nn, md, hl, waddr, wdata;
        logic [1:0] p;
        logic [2:0] dst, src;
        int unsigned len, cost, x, y;
        bit ok, we, word, recheck;
        out_t res;
        op = it.opcode;
        nn = it.operand_bytes;
        n8 = nn[7:0];
        md = it.mem_data;
        mb = md[7:0];
        hl = pair_rd(SLOT_H);
        p = op[5:4];
        dst = op[5:3];
        src = op[2:0];
        len = 1;
        cost = 4;
        ok = 1'b1;
        we = 1'b0;
        word = 1'b0;
        recheck = 1'b0;
        waddr = '0;
        wdata = '0;

        if (op == OP_NOP) begin
            cost = 4;
        end else if (op[7:6] == GRP_MISC) begin
            case (op[3:0])
                LO_LD_RR: begin
                    rr_wr(p, nn);
                    len = 3;
                    cost = 12;
                end
                LO_INC_RR: begin
                    rr_wr(p, rr_rd(p) + 16'd1);
                    cost = 8;
                end
                LO_DEC_RR: begin
                    rr_wr(p, rr_rd(p) - 16'd1);
                    cost = 8;
                end
                LO_ADD_HL: begin
                    x = hl;
                    y = rr_rd(p);
                    cpu_regs[SLOT_F] = (cpu_regs[SLOT_F] & FLAG_Z) |
                        flag_byte(1'b0, 1'b0, ((x & 'hFFF) + (y & 'hFFF)) > 'hFFF,
                                  (x + y) > 'hFFFF);
                    pair_wr(SLOT_H, 16'(x + y));
                    cost = 8;
                end
                default: begin
                    if (src == CODE_INC || src == CODE_DEC) begin
                        if (dst == CODE_HL_MEM) begin
                            we = 1'b1;
                            waddr = hl;
                            wdata = {8'h00, inc_dec_byte(mb, src == CODE_DEC)};
                            cost = 12;
                        end else begin
                            cpu_regs[code_reg(dst)] =
                                inc_dec_byte(cpu_regs[code_reg(dst)], src == CODE_DEC);
                        end
                    end else if (src == CODE_IMM) begin
                        len = 2;
                        if (dst == CODE_HL_MEM) begin
                            we = 1'b1;
                            waddr = hl;
                            wdata = {8'h00, n8};
                            cost = 12;
                        end else begin
                            cpu_regs[code_reg(dst)] = n8;
                            cost = 8;
                        end
                    end else begin
                        ok = 1'b0;
                    end
                end
            endcase
        end else if (op[7:6] == GRP_LD) begin
            if (op == OP_HALT) begin
                ok = 1'b0;
            end else begin
                v = (src == CODE_HL_MEM) ? mb : cpu_regs[code_reg(src)];
                if (dst == CODE_HL_MEM) begin
                    we = 1'b1;
                    waddr = hl;
                    wdata = {8'h00, v};
                    cost = 8;
                end else begin
                    cpu_regs[code_reg(dst)] = v;
                    cost = (src == CODE_HL_MEM) ? 8 : 4;
                end
            end
        end else if (op[7:6] == GRP_ALU) begin
            alu_apply(alu_kind_t'(dst), (src == CODE_HL_MEM) ? mb : cpu_regs[code_reg(src)]);
            cost = (src == CODE_HL_MEM) ? 8 : 4;
        end else if (op[2:0] == CODE_IMM) begin
            alu_apply(alu_kind_t'(dst), n8);
            len = 2;
            cost = 8;
        end else if (op[3:0] == LO_POP) begin
            if (p == PAIR_AF) pair_wr(SLOT_A, md & 16'hFFF0);
            else rr_wr(p, md);
            cpu_sp = cpu_sp + 16'd2;
            cost = 12;
        end else if (op[3:0] == LO_PUSH) begin
            cpu_sp = cpu_sp - 16'd2;
            we = 1'b1;
            word = 1'b1;
            waddr = cpu_sp;
            wdata = (p == PAIR_AF) ? pair_rd(SLOT_A) : rr_rd(p);
            cost = 16;
        end else begin
            ok = 1'b0;
        end

        if (ok) begin
            cpu_pc = cpu_pc + 16'(len);
            cpu_clocks = cpu_clocks + 16'(cost);
            if (we) recheck = word ? (waddr >= ADDR_TOP2) : (waddr == ADDR_TOP);
        end

        res.next_pc = cpu_pc;
        res.af_pair = pair_rd(SLOT_A);
        res.hl_pair = pair_rd(SLOT_H);
        res.stack_ptr = cpu_sp;
        res.write_enable = we;
        res.write_addr = waddr;
        res.write_data = wdata;
        res.write_is_word = word;
        res.cycle_count = cpu_clocks;
        res.recheck_interrupts = recheck;
        res.unsupported_op = !ok;
        return res;
    endfunction

    // ---------------- checking ----------------

    task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] exp_val);
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, exp_val);
        mismatches++;
    endtask

    task automatic check_field(string what, logic [15:0] got, logic [15:0] exp_val);
        if (got !== exp_val) flag_mismatch(what, got, exp_val);
    endtask

    task automatic check_result(out_t got, out_t exp_res);
        check_field("next_pc", got.next_pc, exp_res.next_pc);
        check_field("af_pair", got.af_pair, exp_res.af_pair);
        check_field("hl_pair", got.hl_pair, exp_res.hl_pair);
        check_field("stack_ptr", got.stack_ptr, exp_res.stack_ptr);
        check_field("write_enable", got.write_enable, exp_res.write_enable);
        check_field("write_addr", got.write_addr, exp_res.write_addr);
        check_field("write_data", got.write_data, exp_res.write_data);
        check_field("write_is_word", got.write_is_word, exp_res.write_is_word);
        check_field("cycle_count", got.cycle_count, exp_res.cycle_count);
        check_field("recheck_interrupts", got.recheck_interrupts, exp_res.recheck_interrupts);
        check_field("unsupported_op", got.unsupported_op, exp_res.unsupported_op);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (s_valid && s_ready) predicted_out.push_back(execute_instr(s_data));
            if (m_valid && m_ready) begin
                if (predicted_out.size() == 0) begin
                    flag_mismatch("unexpected transfer, pc", m_data.next_pc, 16'h0000);
                end else begin
                    want = predicted_out.pop_front();
                    check_result(m_data, want);
                end
                results_seen++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, predicted_out.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- driving ----------------

    // sender: bursts of transfers with random gaps in between
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left <= $urandom_range(1, 30);
            gap_left <= 0;
        end else if (!s_valid || s_taken) begin
            if (gap_left != 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (program_items.size() != 0) begin
                s_valid <= 1'b1;
                s_data <= program_items.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches among a few modes
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(40, 120);
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_phase <= rx_phase + 2'd1;
            case (rx_mode)
                RX_FREE:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_phase == 2'd0);
                default:   m_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // ---------------- stimulus ----------------

    function automatic void queue_item(logic [7:0] op, logic [15:0] nn, logic [15:0] md);
        in_t it;
        it.opcode = op;
        it.operand_bytes = nn;
        it.mem_data = md;
        program_items.push_back(it);
    endfunction

    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 5))
                0:       return 16'h0000;
                1:       return 16'hFFFF;
                2:       return 16'hFFFE;
                3:       return 16'h00FF;
                4:       return 16'h000F;
                default: return 16'hFF00;
            endcase
        end
        return 16'($urandom_range(0, 65535));
    endfunction

    // mostly implemented opcodes, with a share of the whole byte space
    function automatic in_t random_item();
        in_t it;
        logic [3:0] lo;
        logic [7:0] op;
        case ($urandom_range(0, 9))
            0, 1, 2: op = 8'($urandom_range(0, 255));
            3, 4, 5: op = 8'($urandom_range(8'h40, 8'hBF));
            6: op = {2'b11, 2'($urandom_range(0, 3)),
                     ($urandom_range(0, 1) != 0) ? LO_PUSH : LO_POP};
            7: op = {2'b11, 3'($urandom_range(0, 7)), CODE_IMM};
            8: begin
                case ($urandom_range(0, 3))
                    0:       lo = LO_LD_RR;
                    1:       lo = LO_INC_RR;
                    2:       lo = LO_ADD_HL;
                    default: lo = LO_DEC_RR;
                endcase
                op = {2'b00, 2'($urandom_range(0, 3)), lo};
            end
            default: op = {2'b00, 3'($urandom_range(0, 7)), 3'($urandom_range(4, 6))};
        endcase
        it.opcode = op;
        it.operand_bytes = pick_word();
        it.mem_data = pick_word();
        return it;
    endfunction

    initial begin
        for (int i = 0; i < 8; i++) cpu_regs[i] = 8'h00;
        cpu_sp = '0;
        cpu_pc = '0;
        cpu_clocks = '0;

        queue_item(OP_NOP, 16'hFFFF, 16'hFFFF);
        queue_item(8'h01, 16'hFFFF, 16'h0000);   // LD BC,FFFF
        queue_item(8'h11, 16'h0000, 16'h0000);   // LD DE,0000
        queue_item(8'h21, 16'hFFFF, 16'h0000);   // LD HL,FFFF
        queue_item(8'h36, 16'hFFA5, 16'h0000);   // LD (HL),n at top of memory
        queue_item(8'h34, 16'h0000, 16'hFFFF);   // INC (HL) wraps to zero
        queue_item(8'h35, 16'h0000, 16'hFF00);   // DEC (HL) half borrow
        queue_item(8'h31, 16'h0000, 16'h0000);   // LD SP,0000
        queue_item(8'hC5, 16'h0000, 16'h0000);   // PUSH BC, SP to FFFE
        queue_item(8'hF1, 16'h0000, 16'hFFFF);   // POP AF, low flag nibble cleared
        queue_item(8'h31, 16'h0001, 16'h0000);   // LD SP,0001
        queue_item(8'hE5, 16'h0000, 16'h0000);   // PUSH HL, SP to FFFF
        queue_item(8'h29, 16'h0000, 16'h0000);   // ADD HL,HL carries
        queue_item(8'h1B, 16'h0000, 16'h0000);   // DEC DE wraps
        queue_item(8'h3E, 16'h000F, 16'h0000);   // LD A,0F
        queue_item(8'hC6, 16'h0001, 16'h0000);   // ADD A,1 half carry
        queue_item(8'hCE, 16'h00FF, 16'h0000);   // ADC A,FF
        queue_item(8'h90, 16'h0000, 16'h0000);   // SUB B borrow
        queue_item(8'hDE, 16'h000F, 16'h0000);   // SBC A,n
        queue_item(8'hA6, 16'h0000, 16'h0000);   // AND (HL) zero
        queue_item(8'hEE, 16'h0055, 16'h0000);   // XOR n
        queue_item(8'hB6, 16'h0000, 16'h00F0);   // OR (HL)
        queue_item(8'hBF, 16'h0000, 16'h0000);   // CP A equal
        queue_item(8'h46, 16'h0000, 16'hAB80);   // LD B,(HL)
        queue_item(8'h77, 16'h0000, 16'h0000);   // LD (HL),A
        queue_item(OP_HALT, 16'h0000, 16'h0000);
        queue_item(8'hC3, 16'h1234, 16'h0000);   // outside the subset
        for (int i = 0; i < RANDOM_ITEMS; i++) program_items.push_back(random_item());

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        while (program_items.size() != 0 || s_valid || predicted_out.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
